### rtl/jsu_pkg.sv
// Shared types, constants and helpers for the JSON string unescaper.
package jsu_pkg;

  // Parser phase within a literal
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_BODY,
    PH_ESC,
    PH_HEX,
    PH_WANTBS,
    PH_WANTU,
    PH_LOWHEX
  } phase_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  // Error codes
  typedef enum logic [2:0] {
    ERR_NO_QUOTE  = 3'd0,
    ERR_BAD_ESC   = 3'd1,
    ERR_BAD_HEX   = 3'd2,
    ERR_NO_LOW    = 3'd3,
    ERR_LOW_RANGE = 3'd4,
    ERR_CTRL      = 3'd5,
    ERR_EARLY_END = 3'd6
  } err_e;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_N = 8'h6E;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_U = 8'h75;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Upper six bits of high and low surrogate units
  localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
  localparam logic [5:0] SURR_LOW_TAG = 6'b110111;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  // Decoder state carried between bytes
  typedef struct packed {
    phase_e      phase;
    logic [9:0]  high_unit;
    logic [15:0] hex_accum;
    logic [1:0]  hex_count;
  } state_t;

  // All results caused by one input beat
  typedef struct packed {
    logic [2:0]      num;
    kind_e           kind;
    err_e            code;
    logic [3:0][7:0] bytes;
  } bundle_t;

  // Hex digit decode: {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

### rtl/jsu_decode.sv
// Per-byte decode step: next parser state and the result bundle for one beat.
module jsu_decode
  import jsu_pkg::*;
(
  input  state_t     state_i,
  input  logic [7:0] in_byte_i,
  input  logic       start_i,
  input  logic       end_i,
  output state_t     state_o,
  output bundle_t    bundle_o
);

  // UTF-8 encoding of one code point, first byte in lane 0
  function automatic bundle_t encode_cp(input logic [20:0] cp);
    bundle_t b;
    b = '0;
    b.kind = KIND_DATA;
    b.code = ERR_NO_QUOTE;
    if (cp <= 21'h7F) begin
      b.num = 3'd1;
      b.bytes[0] = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      b.num = 3'd2;
      b.bytes[0] = {3'b110, cp[10:6]};
      b.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      b.num = 3'd3;
      b.bytes[0] = {4'b1110, cp[15:12]};
      b.bytes[1] = {2'b10, cp[11:6]};
      b.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      b.num = 3'd4;
      b.bytes[0] = {5'b11110, cp[20:18]};
      b.bytes[1] = {2'b10, cp[17:12]};
      b.bytes[2] = {2'b10, cp[11:6]};
      b.bytes[3] = {2'b10, cp[5:0]};
    end
    return b;
  endfunction

  logic [4:0]  digit;
  logic [15:0] unit;
  logic [20:0] pair_cp;

  assign digit = hex_digit(in_byte_i);
  assign unit = {state_i.hex_accum[11:0], digit[3:0]};
  assign pair_cp = SUPP_BASE + {1'b0, state_i.high_unit, unit[9:0]};

  // Decode one byte
  always_comb begin
    state_o = state_i;
    bundle_o = '0;
    bundle_o.kind = KIND_DATA;
    bundle_o.code = ERR_NO_QUOTE;

    if (start_i) begin
      state_o.high_unit = '0;
      state_o.hex_accum = '0;
      state_o.hex_count = '0;
      if (!end_i && in_byte_i == CH_QUOTE) begin
        state_o.phase = PH_BODY;
      end else begin
        state_o.phase = PH_IDLE;
        bundle_o.num = 3'd1;
        bundle_o.kind = KIND_ERROR;
        bundle_o.code = ERR_NO_QUOTE;
      end
    end else if (state_i.phase == PH_IDLE) begin
      state_o.phase = PH_IDLE;
    end else if (end_i) begin
      state_o.phase = PH_IDLE;
      bundle_o.num = 3'd1;
      bundle_o.kind = KIND_ERROR;
      bundle_o.code = ERR_EARLY_END;
    end else begin
      unique case (state_i.phase)
        PH_BODY: begin
          if (in_byte_i == CH_QUOTE) begin
            state_o.phase = PH_IDLE;
            bundle_o.num = 3'd1;
            bundle_o.kind = KIND_CLOSE;
          end else if (in_byte_i == CH_BSLASH) begin
            state_o.phase = PH_ESC;
          end else if (in_byte_i < CH_SPACE) begin
            state_o.phase = PH_IDLE;
            bundle_o.num = 3'd1;
            bundle_o.kind = KIND_ERROR;
            bundle_o.code = ERR_CTRL;
          end else begin
            bundle_o.num = 3'd1;
            bundle_o.bytes[0] = in_byte_i;
          end
        end
        PH_ESC: begin
          state_o.phase = PH_BODY;
          bundle_o.num = 3'd1;
          case (in_byte_i)
            CH_QUOTE, CH_BSLASH, CH_SLASH: bundle_o.bytes[0] = in_byte_i;
            CH_B: bundle_o.bytes[0] = 8'h08;
            CH_F: bundle_o.bytes[0] = 8'h0C;
            CH_N: bundle_o.bytes[0] = 8'h0A;
            CH_R: bundle_o.bytes[0] = 8'h0D;
            CH_T: bundle_o.bytes[0] = 8'h09;
            CH_U: begin
              bundle_o.num = 3'd0;
              state_o.hex_accum = '0;
              state_o.hex_count = '0;
              state_o.phase = PH_HEX;
            end
            default: begin
              state_o.phase = PH_IDLE;
              bundle_o.kind = KIND_ERROR;
              bundle_o.code = ERR_BAD_ESC;
            end
          endcase
        end
        PH_HEX, PH_LOWHEX: begin
          if (!digit[4]) begin
            state_o.phase = PH_IDLE;
            bundle_o.num = 3'd1;
            bundle_o.kind = KIND_ERROR;
            bundle_o.code = ERR_BAD_HEX;
          end else begin
            state_o.hex_accum = unit;
            if (state_i.hex_count != 2'd3) begin
              state_o.hex_count = state_i.hex_count + 2'd1;
            end else begin
              state_o.hex_count = '0;
              if (state_i.phase == PH_HEX) begin
                if (unit[15:10] == SURR_HIGH_TAG) begin
                  state_o.high_unit = unit[9:0];
                  state_o.phase = PH_WANTBS;
                end else begin
                  state_o.phase = PH_BODY;
                  bundle_o = encode_cp({5'd0, unit});
                end
              end else if (unit[15:10] != SURR_LOW_TAG) begin
                state_o.phase = PH_IDLE;
                bundle_o.num = 3'd1;
                bundle_o.kind = KIND_ERROR;
                bundle_o.code = ERR_LOW_RANGE;
              end else begin
                state_o.phase = PH_BODY;
                bundle_o = encode_cp(pair_cp);
              end
            end
          end
        end
        PH_WANTBS: begin
          if (in_byte_i == CH_BSLASH) begin
            state_o.phase = PH_WANTU;
          end else begin
            state_o.phase = PH_IDLE;
            bundle_o.num = 3'd1;
            bundle_o.kind = KIND_ERROR;
            bundle_o.code = ERR_NO_LOW;
          end
        end
        PH_WANTU: begin
          if (in_byte_i == CH_U) begin
            state_o.hex_accum = '0;
            state_o.hex_count = '0;
            state_o.phase = PH_LOWHEX;
          end else begin
            state_o.phase = PH_IDLE;
            bundle_o.num = 3'd1;
            bundle_o.kind = KIND_ERROR;
            bundle_o.code = ERR_NO_LOW;
          end
        end
        default: state_o.phase = PH_IDLE;
      endcase
    end
  end

endmodule

### rtl/json_string_unescape_utf8.sv
// Top level of the JSON string unescaper: state, result buffer and output sequencer.
//
//   channel | direction | signals
//   --------+-----------+--------------------------------------------------------
//   in      | input     | in_valid_i, in_ready_o, in_byte_i, start_of_string_i,
//           |           | end_marker_i
//   out     | output    | out_valid_o, out_ready_i, kind_o, out_byte_o,
//           |           | error_code_o, last_o
//
// One input beat is decoded in the cycle it is accepted; its results (0 to 4) are
// held as one bundle and leave one per cycle from the head register while out_ready_i is high.
// A skid bundle behind the head keeps input flowing while a result is stalled;
// input is held off only when both bundles are occupied.
// A beat that yields n results presents them as n output beats (n = 4 at most).
// Reset clears the parser state and both bundle valid flags; no clearing pass.
module json_string_unescape_utf8
  import jsu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       start_of_string_i,
  input  logic       end_marker_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] out_byte_o,
  output logic [2:0] error_code_o,
  output logic       last_o
);

  state_t  state_q, state_d;
  bundle_t new_bnd;
  bundle_t head_q, head_d, skid_q, skid_d;
  logic    head_v_q, head_v_d, skid_v_q, skid_v_d;
  logic [1:0] idx_q, idx_d;
  logic    in_fire, push, out_fire, head_last, pop, head_free;

  jsu_decode u_decode (
    .state_i   (state_q),
    .in_byte_i (in_byte_i),
    .start_i   (start_of_string_i),
    .end_i     (end_marker_i),
    .state_o   (state_d),
    .bundle_o  (new_bnd)
  );

  // Handshakes
  assign in_ready_o = !skid_v_q;
  assign in_fire = in_valid_i && in_ready_o;
  assign push = in_fire && (new_bnd.num != 3'd0);
  assign out_fire = head_v_q && out_ready_i;
  assign head_last = ({1'b0, idx_q} + 3'd1) == head_q.num;
  assign pop = out_fire && head_last;
  assign head_free = !head_v_q || pop;

  // Bundle buffer control
  always_comb begin
    head_d = head_q;
    head_v_d = head_v_q;
    skid_d = skid_q;
    skid_v_d = skid_v_q;
    idx_d = idx_q;
    if (head_free) begin
      idx_d = '0;
      if (skid_v_q) begin
        head_d = skid_q;
        head_v_d = 1'b1;
        skid_v_d = 1'b0;
      end else if (push) begin
        head_d = new_bnd;
        head_v_d = 1'b1;
      end else begin
        head_v_d = 1'b0;
      end
    end else begin
      if (out_fire) begin
        idx_d = idx_q + 2'd1;
      end
      if (push) begin
        skid_d = new_bnd;
        skid_v_d = 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_IDLE, high_unit: '0, hex_accum: '0, hex_count: '0};
      head_v_q <= 1'b0;
      skid_v_q <= 1'b0;
      idx_q <= '0;
    end else begin
      if (in_fire) begin
        state_q <= state_d;
      end
      head_v_q <= head_v_d;
      skid_v_q <= skid_v_d;
      idx_q <= idx_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  // Output fields
  assign out_valid_o = head_v_q;
  assign kind_o = head_q.kind;
  assign out_byte_o = head_q.bytes[idx_q];
  assign error_code_o = head_q.code;
  assign last_o = head_last;

endmodule

### rtl/jsu_checker.sv
// Port-level checker for the JSON string unescaper, bound to the top level.
module jsu_checker
  import jsu_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] kind_o,
  input logic [7:0] out_byte_o,
  input logic [2:0] error_code_o,
  input logic       last_o
);

  // A stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) &&
    $stable(out_byte_o) && $stable(error_code_o) && $stable(last_o))
    else $error("stalled result beat changed");

  // Close and error results end their beat's results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_DATA |-> last_o)
    else $error("close or error not marked last");

  // Only data results carry a byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_DATA |-> out_byte_o == 8'd0)
    else $error("nonzero byte on close or error");

  // Only error results carry a code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_ERROR |-> error_code_o == ERR_NO_QUOTE)
    else $error("error code on non-error result");

  // Error codes stay in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_ERROR |-> error_code_o != 3'd7)
    else $error("error code out of range");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .kind_o       (kind_o),
  .out_byte_o   (out_byte_o),
  .error_code_o (error_code_o),
  .last_o       (last_o)
);
